>>> rtl/rssi_jamming_alarm_qualifier_assert.svh
// ----------------------------------------------------------------------------
// rssi jamming alarm qualifier assertion macros
// concurrent checks on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef RSSI_JAMMING_ALARM_QUALIFIER_ASSERT_SVH
`define RSSI_JAMMING_ALARM_QUALIFIER_ASSERT_SVH

`ifndef SYNTHESIS
`define RJAQ_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rjaq assertion failed");
`define RJAQ_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rjaq implication failed");
`else
`define RJAQ_ASSERT(lbl, prop)
`define RJAQ_ASSERT_IMP(lbl, ante, cons)
`endif

`endif

>>> rtl/rjaq_pkg.sv
// ----------------------------------------------------------------------------
// rjaq_pkg
// shared constants, word types and codes of the rssi jamming alarm qualifier
// ----------------------------------------------------------------------------
package rjaq_pkg;

    localparam int WINDOW_LEN = 100;
    localparam int FILL_LEN   = 128;
    localparam int LABEL_BITS = 4;

    localparam int PTR_W      = $clog2(WINDOW_LEN);
    localparam int CNT_W      = $clog2(WINDOW_LEN + 1);
    localparam int FILL_W     = $clog2(FILL_LEN + 1);
    localparam int PROB_W     = 16;
    localparam int LVL_W      = 16;
    localparam int FLOOR_W    = 25;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // -85 dB in q8.16
    localparam logic signed [FLOOR_W-1:0] FLOOR_RESET = -25'sd5570560;

    // floor divide by 3 of a biased 20 bit value: (y * recip) >> shift
    localparam logic [20:0] DIV3_RECIP = 21'd1398102;
    localparam int          DIV3_SHIFT = 22;
    // bias 262146 = 3 * 87382, squelch offset 2901 = 11.3333 in q8.8
    localparam logic signed [19:0] DIV3_BIAS_IN  = 20'sd262146;
    localparam logic signed [19:0] SQ_SUB_TOTAL  = 20'sd90283;

    localparam logic [PROB_W-1:0]       CONF_THR_RST = 16'd55706;
    localparam logic [CNT_W-1:0]        TRIG_CNT_RST = CNT_W'(35);
    localparam logic [CNT_W-1:0]        CLR_CNT_RST  = CNT_W'(20);
    localparam logic signed [LVL_W-1:0] SQ_MIN_RST   = -16'sd23040;
    localparam logic signed [LVL_W-1:0] SQ_MAX_RST   = -16'sd17920;
    localparam logic [PROB_W-1:0]       FLOOR_WT_RST = 16'd655;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CONF_THR = 3'd0,
        CFG_TRIG_CNT = 3'd1,
        CFG_CLR_CNT  = 3'd2,
        CFG_SQ_MIN   = 3'd3,
        CFG_SQ_MAX   = 3'd4,
        CFG_FLOOR_WT = 3'd5
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_FLR,
        ST_DIV,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic signed [LVL_W-1:0] rssi;
        logic [PROB_W-1:0]       total_prob;
        logic [PROB_W-1:0]       peak_prob;
        logic [LABEL_BITS-1:0]   peak_label;
        logic                    classifier_ok;
    } sample_t;

    typedef struct packed {
        logic                    alarm;
        logic                    ever_alarmed;
        logic                    attack_frame;
        logic                    squelched;
        logic                    filling;
        logic [CNT_W-1:0]        window_count;
        logic signed [LVL_W-1:0] noise_level;
        logic signed [LVL_W-1:0] squelch_level;
        logic [LABEL_BITS-1:0]   alarm_label;
        logic [PROB_W-1:0]       alarm_total_prob;
        logic [PROB_W-1:0]       alarm_peak_prob;
    } result_t;

    typedef struct packed {
        logic             rd_en;
        logic             wr_en;
        logic [PTR_W-1:0] addr;
        logic             wr_flag;
    } flag_req_t;

endpackage

>>> rtl/rjaq_if.sv
// ----------------------------------------------------------------------------
// rjaq_if
// valid/ready channels for sample words and result words
// ----------------------------------------------------------------------------
interface rjaq_sample_if;
    import rjaq_pkg::*;

    logic    valid;
    logic    ready;
    sample_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rjaq_result_if;
    import rjaq_pkg::*;

    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/rjaq_flag_ram.sv
// ----------------------------------------------------------------------------
// rjaq_flag_ram
// attack flag window memory, one read or write port, registered read data,
// per-entry valid bits so that entries read as clear after reset
// ----------------------------------------------------------------------------
module rjaq_flag_ram (
    input  logic                clk,
    input  logic                rst_n,
    input  rjaq_pkg::flag_req_t req,
    output logic                rd_flag
);
    import rjaq_pkg::*;

    logic                  flag_mem [WINDOW_LEN];
    logic [WINDOW_LEN-1:0] valid_reg;
    logic                  rd_data_reg;
    logic                  rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            flag_mem[req.addr] <= req.wr_flag;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= flag_mem[req.addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_valid_reg <= valid_reg[req.addr];
            end
        end
    end

    assign rd_flag = rd_data_reg & rd_valid_reg;

endmodule

>>> rtl/rssi_jamming_alarm_qualifier.sv
// ----------------------------------------------------------------------------
// rssi_jamming_alarm_qualifier
// noise floor tracking, squelch, sliding window attack count and alarm
//
//   channel   dir  word                     handshake
//   sample    in   rssi, probs, label, ok   valid/ready
//   result    out  alarm state and levels   valid/ready
//   cfg       in   index, data              cfg_wr_en, no wait
//
// each word steps through multiply, floor update, divide-by-3
// multiply, then window read-modify-write on the flag memory
// the next word is taken in the finishing cycle when the output register is free
// a stalled output holds the block in its finishing cycle
// reset clears all control state; window flags read as clear via valid bits
// ----------------------------------------------------------------------------
`include "rssi_jamming_alarm_qualifier_assert.svh"

module rssi_jamming_alarm_qualifier (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [rjaq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rjaq_pkg::CFG_DATA_W-1:0] cfg_wdata,
    rjaq_sample_if.sink                    sample,
    rjaq_result_if.source                  result
);
    import rjaq_pkg::*;

    // configuration
    logic [PROB_W-1:0]       conf_thr_reg;
    logic [CNT_W-1:0]        trig_cnt_reg;
    logic [CNT_W-1:0]        clr_cnt_reg;
    logic signed [LVL_W-1:0] sq_min_reg;
    logic signed [LVL_W-1:0] sq_max_reg;
    logic [PROB_W-1:0]       floor_wt_reg;

    // sequencer
    state_t state_reg;
    state_t state_next;
    logic   out_free;
    logic   fin_go;
    logic   in_acc;
    logic   mul_en;
    logic   flr_en;
    logic   div_en;
    flag_req_t ram_req;
    logic   old_flag;

    // datapath
    sample_t                   in_reg;
    logic signed [42:0]        prod_reg;
    logic signed [FLOOR_W-1:0] floor_reg;
    logic [40:0]               q_prod_reg;

    // window and alarm state
    logic [FILL_W-1:0]     fill_reg;
    logic [PTR_W-1:0]      ptr_reg;
    logic [CNT_W-1:0]      count_reg;
    logic                  alarm_reg;
    logic                  sticky_reg;
    logic [LABEL_BITS-1:0] held_label_reg;
    logic [PROB_W-1:0]     held_total_reg;
    logic [PROB_W-1:0]     held_peak_reg;

    logic [FILL_W-1:0]     fill_next;
    logic [PTR_W-1:0]      ptr_next;
    logic [CNT_W-1:0]      count_next;
    logic                  alarm_next;
    logic                  sticky_next;
    logic [LABEL_BITS-1:0] held_label_next;
    logic [PROB_W-1:0]     held_total_next;
    logic [PROB_W-1:0]     held_peak_next;

    // output register
    logic    out_valid_reg;
    result_t out_reg;
    result_t out_next;

    // ------------------------------------------------------------------
    // configuration writes
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            conf_thr_reg <= CONF_THR_RST;
            trig_cnt_reg <= TRIG_CNT_RST;
            clr_cnt_reg  <= CLR_CNT_RST;
            sq_min_reg   <= SQ_MIN_RST;
            sq_max_reg   <= SQ_MAX_RST;
            floor_wt_reg <= FLOOR_WT_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_CONF_THR: conf_thr_reg <= cfg_wdata[PROB_W-1:0];
                CFG_TRIG_CNT: trig_cnt_reg <= cfg_wdata[CNT_W-1:0];
                CFG_CLR_CNT:  clr_cnt_reg  <= cfg_wdata[CNT_W-1:0];
                CFG_SQ_MIN:   sq_min_reg   <= $signed(cfg_wdata[LVL_W-1:0]);
                CFG_SQ_MAX:   sq_max_reg   <= $signed(cfg_wdata[LVL_W-1:0]);
                CFG_FLOOR_WT: floor_wt_reg <= cfg_wdata[PROB_W-1:0];
                default:      ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    assign out_free = !out_valid_reg || result.ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample.valid)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:  state_next = ST_FLR;
            ST_FLR:  state_next = ST_DIV;
            ST_DIV:  state_next = ST_FIN;
            ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = sample.valid ? ST_MUL : ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    logic win_en;
    logic attack;

    always_comb
    begin
        sample.ready    = 1'b0;
        fin_go          = 1'b0;
        mul_en          = 1'b0;
        flr_en          = 1'b0;
        div_en          = 1'b0;
        ram_req.rd_en   = 1'b0;
        ram_req.wr_en   = 1'b0;
        ram_req.addr    = ptr_reg;
        ram_req.wr_flag = attack;
        unique case (state_reg)
            ST_IDLE: sample.ready = 1'b1;
            ST_MUL:
            begin
                mul_en        = 1'b1;
                ram_req.rd_en = 1'b1;
            end
            ST_FLR:  flr_en = 1'b1;
            ST_DIV:  div_en = 1'b1;
            ST_FIN:
            begin
                sample.ready  = out_free;
                fin_go        = out_free;
                ram_req.wr_en = out_free && win_en;
            end
            default: ;
        endcase
    end

    assign in_acc = sample.valid && sample.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    rjaq_flag_ram u_flag_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (ram_req),
        .rd_flag (old_flag)
    );

    // ------------------------------------------------------------------
    // floor update, held while the alarm is set: floor += floor_div(d * weight + 32768, 65536)
    // ------------------------------------------------------------------
    logic signed [25:0] diff;
    logic signed [42:0] prod;
    logic signed [42:0] prod_rnd;
    logic signed [FLOOR_W-1:0] floor_upd;

    assign diff = $signed({{2{in_reg.rssi[LVL_W-1]}}, in_reg.rssi, 8'd0})
                - $signed({floor_reg[FLOOR_W-1], floor_reg});
    assign prod      = diff * $signed({1'b0, floor_wt_reg});
    assign prod_rnd  = prod_reg + 43'sd32768;
    assign floor_upd = floor_reg + $signed(prod_rnd[40:16]);

    // ------------------------------------------------------------------
    // squelch: floor_div(5 * floor + 768, 1536) - 2901
    // ------------------------------------------------------------------
    logic signed [27:0] fl28;
    logic signed [27:0] sq_t;
    logic signed [18:0] sq_x;
    logic signed [19:0] sq_y;
    logic [40:0]        q_prod;

    assign fl28   = $signed({{3{floor_reg[FLOOR_W-1]}}, floor_reg});
    assign sq_t   = (fl28 <<< 2) + fl28 + 28'sd768;
    assign sq_x   = sq_t[27:9];
    assign sq_y   = $signed({sq_x[18], sq_x}) + DIV3_BIAS_IN;
    assign q_prod = 41'(sq_y[19:0]) * 41'(DIV3_RECIP);

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            in_reg <= sample.data;
        end
        if (mul_en)
        begin
            prod_reg <= prod;
        end
        if (div_en)
        begin
            q_prod_reg <= q_prod;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floor_reg <= FLOOR_RESET;
        end
        else if (flr_en && !alarm_reg)
        begin
            floor_reg <= floor_upd;
        end
    end

    // ------------------------------------------------------------------
    // levels, attack decision and window update
    // ------------------------------------------------------------------
    logic signed [25:0]      noise_sum;
    logic signed [17:0]      noise_q;
    logic signed [LVL_W-1:0] noise_lvl;
    logic signed [19:0]      sq_raw;
    logic signed [19:0]      sq_lo;
    logic signed [19:0]      sq_fin;
    logic signed [19:0]      sq_min20;
    logic signed [19:0]      sq_max20;
    logic signed [19:0]      rssi20;
    logic                    squelched;
    logic                    filling;
    logic [CNT_W-1:0]        count_upd;

    assign noise_sum = $signed({floor_reg[FLOOR_W-1], floor_reg}) + 26'sd128;
    assign noise_q   = noise_sum[25:8];

    always_comb
    begin
        priority if (noise_q > 18'sd32767)
        begin
            noise_lvl = 16'sh7fff;
        end
        else if (noise_q < -18'sd32768)
        begin
            noise_lvl = -16'sd32768;
        end
        else
        begin
            noise_lvl = noise_q[LVL_W-1:0];
        end
    end

    assign sq_raw   = $signed({1'b0, q_prod_reg[40:DIV3_SHIFT]}) - SQ_SUB_TOTAL;
    assign sq_min20 = $signed({{4{sq_min_reg[LVL_W-1]}}, sq_min_reg});
    assign sq_max20 = $signed({{4{sq_max_reg[LVL_W-1]}}, sq_max_reg});
    assign rssi20   = $signed({{4{in_reg.rssi[LVL_W-1]}}, in_reg.rssi});
    assign sq_lo    = (sq_raw < sq_min20) ? sq_min20 : sq_raw;
    assign sq_fin   = (sq_lo > sq_max20) ? sq_max20 : sq_lo;
    assign squelched = rssi20 < sq_fin;

    assign filling   = fill_reg < FILL_W'(FILL_LEN);
    assign win_en    = !filling && in_reg.classifier_ok;
    assign attack    = win_en && !squelched && (in_reg.total_prob >= conf_thr_reg);
    assign count_upd = count_reg - CNT_W'(old_flag) + CNT_W'(attack);

    always_comb
    begin
        fill_next       = fill_reg;
        ptr_next        = ptr_reg;
        count_next      = count_reg;
        alarm_next      = alarm_reg;
        sticky_next     = sticky_reg;
        held_label_next = held_label_reg;
        held_total_next = held_total_reg;
        held_peak_next  = held_peak_reg;
        if (filling)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (win_en)
        begin
            count_next = count_upd;
            ptr_next   = (ptr_reg == PTR_W'(WINDOW_LEN - 1)) ? '0 : ptr_reg + 1'b1;
            priority if (count_upd >= trig_cnt_reg)
            begin
                alarm_next      = 1'b1;
                sticky_next     = 1'b1;
                held_label_next = in_reg.peak_label;
                held_total_next = squelched ? '0 : in_reg.total_prob;
                held_peak_next  = in_reg.peak_prob;
            end
            else if (count_upd <= clr_cnt_reg)
            begin
                alarm_next = 1'b0;
            end
            else
            begin
                alarm_next = alarm_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg       <= '0;
            ptr_reg        <= '0;
            count_reg      <= '0;
            alarm_reg      <= 1'b0;
            sticky_reg     <= 1'b0;
            held_label_reg <= '0;
            held_total_reg <= '0;
            held_peak_reg  <= '0;
        end
        else if (fin_go)
        begin
            fill_reg       <= fill_next;
            ptr_reg        <= ptr_next;
            count_reg      <= count_next;
            alarm_reg      <= alarm_next;
            sticky_reg     <= sticky_next;
            held_label_reg <= held_label_next;
            held_total_reg <= held_total_next;
            held_peak_reg  <= held_peak_next;
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_comb
    begin
        out_next.alarm            = alarm_next;
        out_next.ever_alarmed     = sticky_next;
        out_next.attack_frame     = attack;
        out_next.squelched        = squelched;
        out_next.filling          = filling;
        out_next.window_count     = count_next;
        out_next.noise_level      = noise_lvl;
        out_next.squelch_level    = sq_fin[LVL_W-1:0];
        out_next.alarm_label      = held_label_next;
        out_next.alarm_total_prob = held_total_next;
        out_next.alarm_peak_prob  = held_peak_next;
    end

    always_ff @(posedge clk)
    begin
        if (fin_go)
        begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fin_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `RJAQ_ASSERT(a_fin_stall, (state_reg == ST_FIN && !fin_go) |=> (state_reg == ST_FIN))
    `RJAQ_ASSERT_IMP(a_ready_state, sample.ready, state_reg == ST_IDLE || state_reg == ST_FIN)
    `RJAQ_ASSERT(a_fin_out, fin_go |=> out_valid_reg)
    `RJAQ_ASSERT_IMP(a_sticky, alarm_reg, sticky_reg)
    `RJAQ_ASSERT(a_count_hold, !fin_go |=> $stable(count_reg))

endmodule
